FILE: sv/itf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itf_pkg
// Shared types, codes and character constants for the integer text formatter.
// ----------------------------------------------------------------------------
package itf_pkg;

    // conversion kinds carried in the request
    localparam logic [1:0] OP_SDEC = 2'd0;
    localparam logic [1:0] OP_UDEC = 2'd1;
    localparam logic [1:0] OP_HEX  = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    // ascii characters used in the field
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LOW_A = 8'h61;

    // most digits of a 32-bit value in base ten
    localparam int DIG_MAX = 10;
    localparam int DIG_IW  = 4;

    // reciprocal of ten, exact for every 32-bit dividend with a shift of 35
    localparam logic [31:0] RECIP10 = 32'hcccc_cccd;
    localparam int          RECIP_SH = 35;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEX,
        S_MUL,
        S_REM,
        S_SETUP,
        S_EMIT
    } t_state;

    // digit value to lowercase ascii
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {4'b0, d};
        end else begin
            c = CH_LOW_A + {4'b0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

FILE: sv/integer_text_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_text_formatter
// Formats one integer conversion as padded ascii text, one character a beat.
// ----------------------------------------------------------------------------
// Usage
//   Slave stream takes one conversion request: the kind of conversion on
//   tuser, and value, field width, left-justify and zero-fill flags and the
//   room left in the output buffer on tdata. Master stream returns the
//   characters of the field, one per beat, with tlast on the final character
//   sent for that request. A room of zero or the unused opcode gives no beats.
// Sequencing
//   Decimal digits come from a shared 32x32 reciprocal multiplier followed by
//   a remainder step, a multiply state and a remainder state per digit. Hex
//   digits take one shift step each. A setup step then fixes the field, and
//   one character leaves per cycle while the receiver takes them. tready
//   stays low from acceptance until the last character is loaded, or until
//   setup ends when the field has no characters; the unused opcode keeps it high.
// Reset and stalls
//   Synchronous active-low reset returns the sequencer to idle and drops the
//   output beat. When the receiver stalls, the output register holds its
//   character and the sequencer waits; no character is lost or repeated.
// ----------------------------------------------------------------------------
module integer_text_formatter
    import itf_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // value[31:0], field_width[37:32], left_just[38], zero_fill[39],
    // room[45:40]
    input  logic [47:0] i_s_tdata,
    // opcode[1:0]
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // ch[7:0]
    output logic [7:0]  o_m_tdata,
    output logic        o_m_tlast
);

    localparam int VB = VALUE_BITS;

    // request fields
    logic [1:0]    w_op;
    logic [VB-1:0] w_val;
    logic [5:0]    w_width;
    logic          w_left;
    logic          w_zpad;
    logic [5:0]    w_room;

    assign w_op    = i_s_tuser;
    assign w_val   = i_s_tdata[0 +: VB];
    assign w_width = i_s_tdata[37:32];
    assign w_left  = i_s_tdata[38];
    assign w_zpad  = i_s_tdata[39];
    assign w_room  = i_s_tdata[45:40];

    t_state r_state, n_state;

    logic [VB-1:0]     r_mag;
    logic              r_neg;
    logic              r_left;
    logic              r_zpad;
    logic [5:0]        r_width;
    logic [5:0]        r_room;
    logic [63:0]       r_prod;
    logic [3:0]        r_digits [DIG_MAX];
    logic [DIG_IW-1:0] r_nd;
    logic [5:0]        r_len;
    logic [5:0]        r_start;
    logic [5:0]        r_emit;
    logic [5:0]        r_pos;
    logic              r_m_valid;
    logic [7:0]        r_m_ch;
    logic              r_m_last;

    logic w_accept;
    logic w_load;
    logic w_in_ready;

    assign w_accept = i_s_tvalid && w_in_ready;

    // sign and magnitude at acceptance
    logic          w_neg;
    logic [VB-1:0] w_mag;

    assign w_neg = (w_op == OP_SDEC) && w_val[VB-1];
    assign w_mag = w_neg ? (~w_val + VB'(1)) : w_val;

    // quotient and remainder from the registered product
    logic [31:0]   w_mag32;
    logic [31:0]   w_q32;
    logic [VB-1:0] w_q;
    logic [31:0]   w_rem32;
    logic [VB-1:0] w_hex_next;

    assign w_mag32    = 32'(r_mag);
    assign w_q32      = {3'b0, r_prod[63:RECIP_SH]};
    assign w_q        = w_q32[VB-1:0];
    assign w_rem32    = w_mag32 - (w_q32 << 3) - (w_q32 << 1);
    assign w_hex_next = r_mag >> 4;

    // field geometry for the setup step
    logic [5:0] w_len;
    logic [5:0] w_total;

    assign w_len   = {2'b0, r_nd} + {5'b0, r_neg};
    assign w_total = (r_width > w_len) ? r_width : w_len;

    // character at the current position
    logic [5:0]        w_j;
    logic [DIG_IW-1:0] w_k;
    logic [DIG_IW-1:0] w_idx;
    logic [7:0]        w_ch;
    logic              w_last;

    assign w_j    = r_pos - r_start;
    assign w_k    = w_j[DIG_IW-1:0] - {{(DIG_IW-1){1'b0}}, r_neg};
    assign w_idx  = r_nd - DIG_IW'(1) - w_k;
    assign w_last = (r_pos == r_emit - 6'd1);

    always_comb begin
        if (r_pos < r_start) begin
            w_ch = r_zpad ? CH_ZERO : CH_SPACE;
        end else if (w_j < r_len) begin
            if (r_neg && (w_j == 6'd0)) begin
                w_ch = CH_MINUS;
            end else begin
                w_ch = digit_char(r_digits[w_idx]);
            end
        end else begin
            w_ch = CH_SPACE;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (w_op)
                        OP_SDEC, OP_UDEC: n_state = S_MUL;
                        OP_HEX:           n_state = S_HEX;
                        default:          n_state = S_IDLE;
                    endcase
                end
            end
            S_HEX: begin
                if (w_hex_next == '0) begin
                    n_state = S_SETUP;
                end
            end
            S_MUL: n_state = S_REM;
            S_REM: begin
                n_state = (w_q == '0) ? S_SETUP : S_MUL;
            end
            S_SETUP: begin
                n_state = (((w_total < r_room) ? w_total : r_room) == 6'd0) ? S_IDLE
                                                                             : S_EMIT;
            end
            S_EMIT: begin
                if (w_load && w_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // decoded controls
    always_comb begin
        w_in_ready = 1'b0;
        w_load     = 1'b0;
        case (r_state)
            S_IDLE:  w_in_ready = 1'b1;
            S_EMIT:  w_load     = !r_m_valid || i_m_tready;
            default: begin
                w_in_ready = 1'b0;
                w_load     = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_mag   <= w_mag;
                    r_neg   <= w_neg;
                    r_left  <= w_left;
                    r_zpad  <= w_zpad && !w_left;
                    r_width <= w_width;
                    r_room  <= w_room;
                    r_nd    <= '0;
                end
            end
            S_HEX: begin
                r_digits[r_nd] <= r_mag[3:0];
                r_nd           <= r_nd + DIG_IW'(1);
                r_mag          <= w_hex_next;
            end
            S_MUL: begin
                r_prod <= 64'(w_mag32) * 64'(RECIP10);
            end
            S_REM: begin
                r_digits[r_nd] <= w_rem32[3:0];
                r_nd           <= r_nd + DIG_IW'(1);
                r_mag          <= w_q;
            end
            S_SETUP: begin
                r_len   <= w_len;
                r_start <= r_left ? 6'd0 : (w_total - w_len);
                r_emit  <= (w_total < r_room) ? w_total : r_room;
                r_pos   <= 6'd0;
            end
            S_EMIT: begin
                if (w_load) begin
                    r_m_ch   <= w_ch;
                    r_m_last <= w_last;
                    r_pos    <= r_pos + 6'd1;
                end
            end
            default: begin
                r_pos <= r_pos;
            end
        endcase
    end

    assign o_s_tready = w_in_ready;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_ch;
    assign o_m_tlast  = r_m_last;

    // a valid conversion request always starts digit work
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_op != OP_NONE)) |=> (r_state != S_IDLE))
        else $error("valid request did not start conversion");

    // the digit buffer never overflows
    a_digit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_HEX) || (r_state == S_REM)) |-> (r_nd < DIG_IW'(DIG_MAX)))
        else $error("digit buffer overflow");

    // loading the final character ends emission with that character presented
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && w_load && w_last)
            |=> ((r_state == S_IDLE) && r_m_valid && r_m_last))
        else $error("emission did not end on final character");

    // emission only runs with a non-zero character count
    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> ((r_emit != 6'd0) && (r_pos < r_emit)))
        else $error("emission position out of range");

endmodule

FILE: tb/integer_text_formatter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_text_formatter_tb
// Self-checking stream testbench for the integer text formatter.
// ----------------------------------------------------------------------------
// A queue of conversion requests (a directed set, then random ones) feeds a
// clocked driver with random gaps. Each accepted request is formatted by a
// local printf-style model into the expected characters. A clocked monitor
// applies random back-pressure and one long hold-off, and compares every
// character and its tlast flag with the oldest expected one.
// ----------------------------------------------------------------------------
module integer_text_formatter_tb;
    import itf_pkg::*;

    localparam int unsigned RANDOM_REQS = 447;
    localparam int unsigned GAP_MAX     = 17;
    localparam int unsigned HOLD_AT     = 500;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned DRAIN_WAIT  = 60;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned ERR_SHOWN   = 10;

    // one conversion request
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] value;
        logic [5:0]  width;
        logic        left;
        logic        zpad;
        logic [5:0]  room;
    } t_conv;

    // one character beat of the field
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char_beat;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // value[31:0], field_width[37:32], left_just[38], zero_fill[39],
    // room[45:40]
    logic [47:0] s_tdata = '0;
    // opcode[1:0]
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // ch[7:0]
    logic [7:0]  m_tdata;
    logic        m_tlast;

    t_conv       conv_pending[$];
    t_char_beat  chars_due[$];

    int unsigned n_req = 0;
    int unsigned n_cut = 0;
    int unsigned n_chars = 0;
    int unsigned n_err = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;

    integer_text_formatter dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // request data fields packed lowest first, opcode travels on tuser
    function automatic logic [47:0] pack_conv(input t_conv c);
        return {2'b00, c.room, c.zpad, c.left, c.width, c.value};
    endfunction

    // lowercase ascii for one digit value
    function automatic logic [7:0] digit_ascii(input logic [31:0] d);
        logic [7:0] c;
        if (d < 32'd10) begin
            c = CH_ZERO + d[7:0];
        end else begin
            c = CH_LOW_A + d[7:0] - 8'd10;
        end
        return c;
    endfunction

    // format one conversion and queue the characters the block must send
    function automatic void format_field(input t_conv c);
        logic [7:0]  text[$];
        logic [7:0]  field[$];
        logic [31:0] mag;
        logic [31:0] base;
        int unsigned pad;
        int unsigned emit;
        t_char_beat  beat;
        if (c.op == OP_NONE) begin
            return;
        end
        mag  = c.value;
        base = (c.op == OP_HEX) ? 32'd16 : 32'd10;
        // magnitude of a negative signed value, wraps for the most negative
        if (c.op == OP_SDEC && mag[31]) begin
            mag = ~mag + 32'd1;
        end
        do begin
            text.push_front(digit_ascii(mag % base));
            mag = mag / base;
        end while (mag != 32'd0);
        if (c.op == OP_SDEC && c.value[31]) begin
            text.push_front(CH_MINUS);
        end
        pad = (c.width > text.size()) ? c.width - text.size() : 0;
        // zeros of a right-aligned field go ahead of the minus sign
        if (!c.left) begin
            for (int i = 0; i < pad; i++) begin
                field.push_back(c.zpad ? CH_ZERO : CH_SPACE);
            end
        end
        foreach (text[i]) begin
            field.push_back(text[i]);
        end
        if (c.left) begin
            for (int i = 0; i < pad; i++) begin
                field.push_back(CH_SPACE);
            end
        end
        // room caps the count, leading characters kept
        emit = (field.size() < c.room) ? field.size() : c.room;
        if (emit < field.size()) begin
            n_cut++;
        end
        for (int i = 0; i < emit; i++) begin
            beat.ch   = field[i];
            beat.last = (i + 1 == emit);
            chars_due.push_back(beat);
        end
    endfunction

    function automatic void report(input string msg);
        n_err++;
        if (n_err <= ERR_SHOWN) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endfunction

    // compare one received character with the oldest expected one
    function automatic void check_char(input logic [7:0] ch, input logic last);
        t_char_beat e;
        if (chars_due.size() == 0) begin
            report($sformatf("character %h (last %0b) with none expected", ch, last));
        end else begin
            e = chars_due.pop_front();
            if (ch !== e.ch) begin
                report($sformatf("character expected %h, got %h", e.ch, ch));
            end
            if (last !== e.last) begin
                report($sformatf("tlast expected %0b, got %0b", e.last, last));
            end
        end
    endfunction

    function automatic void add_conv(input logic [1:0] op, input logic [31:0] value,
                                     input logic [5:0] width, input logic left,
                                     input logic zpad, input logic [5:0] room);
        t_conv c;
        c.op    = op;
        c.value = value;
        c.width = width;
        c.left  = left;
        c.zpad  = zpad;
        c.room  = room;
        conv_pending.push_back(c);
    endfunction

    // random request, mostly well formed with varied sizes
    function automatic t_conv random_conv();
        t_conv c;
        int unsigned k;
        c.op = ($urandom_range(0, 19) == 0) ? OP_NONE : 2'($urandom_range(0, 2));
        case ($urandom_range(0, 7))
            0: c.value = $urandom_range(0, 99);
            1: c.value = -$urandom_range(1, 1000);
            2: begin
                k = $urandom_range(0, 3);
                c.value = (k == 0) ? 32'h8000_0000 : (k == 1) ? 32'h7fff_ffff :
                          (k == 2) ? 32'hffff_ffff : 32'h0;
            end
            3: c.value = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
            4: c.value = $urandom_range(0, 65535);
            default: c.value = $urandom;
        endcase
        c.width = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 14))
                                              : 6'($urandom_range(0, 63));
        c.left  = 1'($urandom_range(0, 1));
        c.zpad  = 1'($urandom_range(0, 1));
        k = $urandom_range(0, 19);
        c.room  = (k < 12) ? 6'($urandom_range(12, 63)) :
                  (k < 17) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 6));
        return c;
    endfunction

    // driver: one request per handshake, random gaps with burst stretches
    always @(posedge clk) begin : drive
        static t_conv       cur_conv;
        static int unsigned gap_left = 0;
        static int unsigned n_loaded = 0;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                format_field(cur_conv);
                n_req <= n_req + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (conv_pending.size() != 0) begin
                    cur_conv = conv_pending.pop_front();
                    s_tdata  <= pack_conv(cur_conv);
                    s_tuser  <= cur_conv.op;
                    s_tvalid <= 1'b1;
                    n_loaded++;
                    gap_left = ((n_loaded / 40) % 4 == 1) ? 0 : $urandom_range(0, GAP_MAX);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each character, random stalls with burst stretches
    always @(posedge clk) begin : watch
        static int unsigned stall_left = 0;
        if (!rst_n) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_char(m_tdata, m_tlast);
                n_chars <= n_chars + 1;
                stall_left = ((n_chars / 150) % 3 == 2) ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // one long receiver hold-off so the block backs up onto its input
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && n_chars >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // stimulus, reset and end of run
    initial begin
        int unsigned cycles;
        logic        timed_out;
        // directed: zeros, extremes, padding forms, truncation, ignored requests
        add_conv(OP_SDEC, 32'd0, 6'd0, 1'b0, 1'b0, 6'd63);
        add_conv(OP_UDEC, 32'd0, 6'd0, 1'b0, 1'b0, 6'd63);
        add_conv(OP_HEX, 32'd0, 6'd0, 1'b0, 1'b0, 6'd63);
        add_conv(OP_SDEC, -32'sd42, 6'd6, 1'b0, 1'b1, 6'd63);
        add_conv(OP_SDEC, -32'sd42, 6'd6, 1'b0, 1'b0, 6'd63);
        add_conv(OP_SDEC, -32'sd42, 6'd6, 1'b1, 1'b1, 6'd63);
        add_conv(OP_SDEC, 32'h8000_0000, 6'd0, 1'b0, 1'b0, 6'd63);
        add_conv(OP_SDEC, 32'h8000_0000, 6'd12, 1'b0, 1'b1, 6'd63);
        add_conv(OP_SDEC, 32'h7fff_ffff, 6'd15, 1'b0, 1'b1, 6'd63);
        add_conv(OP_SDEC, 32'hffff_ffff, 6'd0, 1'b0, 1'b0, 6'd63);
        add_conv(OP_UDEC, 32'hffff_ffff, 6'd0, 1'b0, 1'b0, 6'd63);
        add_conv(OP_UDEC, 32'd1_000_000_000, 6'd0, 1'b0, 1'b0, 6'd63);
        add_conv(OP_HEX, 32'hffff_ffff, 6'd10, 1'b1, 1'b0, 6'd63);
        add_conv(OP_HEX, 32'hdead_beef, 6'd9, 1'b1, 1'b1, 6'd63);
        add_conv(OP_UDEC, 32'd123, 6'd63, 1'b0, 1'b1, 6'd63);
        add_conv(OP_SDEC, -32'sd1, 6'd63, 1'b1, 1'b0, 6'd63);
        add_conv(OP_HEX, 32'h0000_0abc, 6'd20, 1'b0, 1'b0, 6'd0);
        add_conv(OP_NONE, 32'd5, 6'd5, 1'b0, 1'b0, 6'd63);
        add_conv(OP_NONE, 32'hffff_ffff, 6'd63, 1'b1, 1'b1, 6'd63);
        add_conv(OP_UDEC, 32'hffff_ffff, 6'd0, 1'b0, 1'b0, 6'd3);
        add_conv(OP_SDEC, -32'sd7, 6'd0, 1'b0, 1'b0, 6'd1);
        add_conv(OP_HEX, 32'h1234_abcd, 6'd63, 1'b0, 1'b1, 6'd40);
        add_conv(OP_UDEC, 32'd5, 6'd1, 1'b0, 1'b0, 6'd63);
        // random part
        for (int i = 0; i < RANDOM_REQS; i++) begin
            conv_pending.push_back(random_conv());
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        // wait for every request to be taken and every character returned
        cycles = 0;
        while (!(conv_pending.size() == 0 && !s_tvalid && chars_due.size() == 0)
               && cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        timed_out = (cycles >= CYCLE_LIMIT);
        if (!timed_out) begin
            repeat (DRAIN_WAIT) @(posedge clk);
        end
        if (chars_due.size() != 0) begin
            report($sformatf("%0d characters never arrived", chars_due.size()));
        end
        $display("run covered %0d conversions (%0d cut short by room), %0d characters",
                 n_req, n_cut, n_chars);
        $display("timeout %0b, %0d mismatches", timed_out, n_err);
        if (!timed_out && n_err == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: integer_text_formatter.f
sv/itf_pkg.sv
sv/integer_text_formatter.sv
tb/integer_text_formatter_tb.sv
